### hdl/ipm_pkg.sv
// ----------------------------------------------------------------------------
// ipm_pkg
// Shared types and constants for the integer polynomial multiplier.
// ----------------------------------------------------------------------------
package ipm_pkg;

  localparam int COEF_W  = 32;
  localparam int POWER_W = 5;

  localparam logic OP_LOAD_FIRST  = 1'b0;
  localparam logic OP_LOAD_SECOND = 1'b1;

  // Control that travels with each multiply-accumulate term.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

### hdl/ipm_mac.sv
// ----------------------------------------------------------------------------
// ipm_mac
// Two-stage multiply-accumulate: a registered 32x32 product (low 32 bits),
// then an accumulator that restarts on the first term of a coefficient.
// ----------------------------------------------------------------------------
module ipm_mac import ipm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  mac_ctl_t          ctl_i,
  input  logic [COEF_W-1:0] a_i,
  input  logic [COEF_W-1:0] b_i,
  output logic [COEF_W-1:0] sum_o,
  output logic              done_o
);

  mac_ctl_t          ctl1_r;
  logic [COEF_W-1:0] prod_r;
  logic [COEF_W-1:0] acc_r;
  logic              done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctl1_r <= ctl_i;
      done_r <= ctl1_r.valid && ctl1_r.last;
    end
  end

  // Only the low word of the product is kept; it is the same for signed
  // and unsigned operands.
  always_ff @(posedge clk) begin
    prod_r <= a_i * b_i;
    if (ctl1_r.valid) begin
      acc_r <= ctl1_r.first ? prod_r : acc_r + prod_r;
    end
  end

  assign sum_o  = acc_r;
  assign done_o = done_r;

endmodule

### hdl/integer_polynomial_multiply.sv
// Loads are accepted back to back while idle; the input is stalled while a product runs.
// Output power k issues n_k = min(k, da) - max(0, k - db) + 1 terms through
// the one shared multiplier, then passes the operand, product and accumulator registers.
// A full run of degree 15 by 15 issues 256 terms.
// Reset clears the counts, the overflow flag and the handshakes; the stores
// are not swept, since the counts keep unwritten entries from being read.
// ----------------------------------------------------------------------------
// integer_polynomial_multiply
// Loads two coefficient stores and, on a second-polynomial load marked last,
// streams their product one output coefficient at a time, from power zero up to the sum of the degrees.
// ----------------------------------------------------------------------------
module integer_polynomial_multiply import ipm_pkg::*; #(
  parameter int MAX_DEGREE = 15
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_operation,
  input  logic signed [COEF_W-1:0]  in_coefficient,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COEF_W-1:0]  out_product_coefficient,
  output logic [POWER_W-1:0]        out_power,
  output logic                      out_final_term,
  output logic                      out_overflow
);

  localparam int DEPTH = MAX_DEGREE + 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int K_W   = $clog2(2 * MAX_DEGREE + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_EMIT
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   first_count_r;
  logic [CNT_W-1:0]   second_count_r;
  logic               overflow_r;
  logic [K_W-1:0]     k_r;
  logic [IDX_W-1:0]   i_r;
  logic               first_r;
  logic               out_valid_r;
  logic [COEF_W-1:0]  out_coef_r;
  logic [POWER_W-1:0] out_power_r;
  logic               out_final_r;
  logic               out_overflow_r;

  logic [COEF_W-1:0]  first_mem [DEPTH];
  logic [COEF_W-1:0]  second_mem [DEPTH];
  logic [COEF_W-1:0]  a_q;
  logic [COEF_W-1:0]  b_q;
  mac_ctl_t           ctl_q;

  logic               in_acc;
  logic               first_full;
  logic               second_full;
  logic               wr_first;
  logic               wr_second;
  logic [IDX_W-1:0]   da;
  logic [IDX_W-1:0]   db;
  logic [K_W-1:0]     top;
  logic [K_W-1:0]     kn;
  logic [IDX_W-1:0]   i_lo_n;
  logic [IDX_W-1:0]   i_hi;
  logic [IDX_W-1:0]   rd_b;
  logic               last_issue;
  logic               is_final;
  logic               out_free;
  logic               emit;
  mac_ctl_t           ctl_issue;
  logic [COEF_W-1:0]  a_op;
  logic [COEF_W-1:0]  b_op;
  logic [COEF_W-1:0]  mac_sum;
  logic               mac_done;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    first_full  = (first_count_r == CNT_W'(DEPTH));
    second_full = (second_count_r == CNT_W'(DEPTH));
    wr_first    = in_acc && (in_operation == OP_LOAD_FIRST) && !first_full;
    wr_second   = in_acc && (in_operation == OP_LOAD_SECOND) && !second_full;

    // An empty polynomial behaves as the single coefficient zero.
    da = (first_count_r == '0) ? '0 : IDX_W'(first_count_r - CNT_W'(1));
    db = (second_count_r == '0) ? '0 : IDX_W'(second_count_r - CNT_W'(1));
    top = K_W'(da) + K_W'(db);

    // Only the terms i with 0 <= k - i <= db are issued.
    kn     = k_r + K_W'(1);
    i_lo_n = (kn > K_W'(db)) ? IDX_W'(kn - K_W'(db)) : '0;
    i_hi   = (k_r < K_W'(da)) ? IDX_W'(k_r) : da;
    rd_b   = IDX_W'(k_r - K_W'(i_r));

    last_issue = (i_r == i_hi);
    is_final   = (k_r == top);
    out_free   = !out_valid_r || !out_stall;
    emit       = ((state_r == ST_WAIT && mac_done) || state_r == ST_EMIT) && out_free;

    ctl_issue.valid = (state_r == ST_ISSUE);
    ctl_issue.first = first_r;
    ctl_issue.last  = last_issue;

    a_op = (first_count_r == '0) ? '0 : a_q;
    b_op = (second_count_r == '0) ? '0 : b_q;
  end

  always_ff @(posedge clk) begin
    if (wr_first) begin
      first_mem[IDX_W'(first_count_r)] <= in_coefficient;
    end
    a_q <= first_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (wr_second) begin
      second_mem[IDX_W'(second_count_r)] <= in_coefficient;
    end
    b_q <= second_mem[rd_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      first_count_r  <= '0;
      second_count_r <= '0;
      overflow_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      ctl_q          <= '0;
      first_r        <= 1'b0;
    end else begin
      ctl_q <= ctl_issue;
      if (out_valid_r && !out_stall && !emit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r) inside
        ST_IDLE: begin
          if (in_acc) begin
            if (in_operation == OP_LOAD_FIRST) begin
              if (first_full) begin
                overflow_r <= 1'b1;
              end else begin
                first_count_r <= first_count_r + CNT_W'(1);
              end
            end else begin
              if (second_full) begin
                overflow_r <= 1'b1;
              end else begin
                second_count_r <= second_count_r + CNT_W'(1);
              end
              if (in_last) begin
                state_r <= ST_ISSUE;
                k_r     <= '0;
                i_r     <= '0;
                first_r <= 1'b1;
              end
            end
          end
        end
        ST_ISSUE: begin
          first_r <= 1'b0;
          if (last_issue) begin
            state_r <= ST_WAIT;
          end else begin
            i_r <= i_r + IDX_W'(1);
          end
        end
        ST_WAIT, ST_EMIT: begin
          if (emit) begin
            out_valid_r    <= 1'b1;
            out_coef_r     <= mac_sum;
            out_power_r    <= POWER_W'(k_r);
            out_final_r    <= is_final;
            out_overflow_r <= overflow_r;
            if (is_final) begin
              first_count_r  <= '0;
              second_count_r <= '0;
              overflow_r     <= 1'b0;
              state_r        <= ST_IDLE;
            end else begin
              k_r     <= kn;
              i_r     <= i_lo_n;
              first_r <= 1'b1;
              state_r <= ST_ISSUE;
            end
          end else if (state_r == ST_WAIT && mac_done) begin
            state_r <= ST_EMIT;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  ipm_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_q),
    .a_i    (a_op),
    .b_i    (b_op),
    .sum_o  (mac_sum),
    .done_o (mac_done)
  );

  assign out_valid               = out_valid_r;
  assign out_product_coefficient = out_coef_r;
  assign out_power               = out_power_r;
  assign out_final_term          = out_final_r;
  assign out_overflow            = out_overflow_r;

`ifndef ASSERT_OFF
  // A finished sum only arrives while the sequencer is waiting for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == ST_WAIT)
    else $error("accumulated sum finished outside the wait state");

  // Every issued term reads inside both loaded polynomials.
  a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_issue.valid |-> (i_r <= da) && (rd_b <= db))
    else $error("term read outside the loaded coefficients");

  // A result is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !(out_valid_r && out_stall))
    else $error("output register overwritten while stalled");

  // The final coefficient of a run leaves both stores empty.
  a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && is_final) |=> (first_count_r == '0) && (second_count_r == '0) && !overflow_r)
    else $error("counts not cleared after the final coefficient");
`endif

endmodule

### dv/tb_integer_polynomial_multiply.sv
// ----------------------------------------------------------------------------
// tb_integer_polynomial_multiply
// Self-checking bench for the integer polynomial multiplier. It loads
// coefficient sequences, predicts every product term of a run when its closing request is
// accepted, and compares the result stream field by field. The run passes
// through phases of random source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_integer_polynomial_multiply import ipm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DEGREE   = 15;
  localparam int STORE_DEPTH  = MAX_DEGREE + 1;
  localparam int RANDOM_ITEMS = 210;
  localparam int PHASES       = 4;

  typedef struct {
    logic signed [COEF_W-1:0] coef;
    logic [POWER_W-1:0]       power;
    logic                     final_term;
    logic                     overflow;
  } product_term_t;

  // Keeps its own copy of both coefficient stores and expands each completed
  // second polynomial into the terms the block should stream out.
  class poly_product_model;
    logic [COEF_W-1:0] first_store[STORE_DEPTH];
    logic [COEF_W-1:0] second_store[STORE_DEPTH];
    int unsigned       first_count;
    int unsigned       second_count;
    logic              overflow_seen;
    product_term_t     pending_terms[$];
    int                errors;
    int                terms_checked;
    int                runs;
    int                overflow_runs;

    function new();
      clear_stores();
      errors = 0;
      terms_checked = 0;
      runs = 0;
      overflow_runs = 0;
    endfunction

    function void clear_stores();
      foreach (first_store[i]) begin
        first_store[i] = '0;
        second_store[i] = '0;
      end
      first_count = 0;
      second_count = 0;
      overflow_seen = 1'b0;
    endfunction

    function void note_request(logic op, logic [COEF_W-1:0] coef, logic lst);
      int unsigned   da;
      int unsigned   db;
      logic [COEF_W-1:0] acc;
      product_term_t t;
      if (op == OP_LOAD_FIRST) begin
        if (first_count < STORE_DEPTH) begin
          first_store[first_count] = coef;
          first_count++;
        end else begin
          overflow_seen = 1'b1;
        end
        return;
      end
      if (second_count < STORE_DEPTH) begin
        second_store[second_count] = coef;
        second_count++;
      end else begin
        overflow_seen = 1'b1;
      end
      if (!lst) return;
      // An empty polynomial behaves as the single coefficient zero.
      da = (first_count != 0) ? first_count - 1 : 0;
      db = (second_count != 0) ? second_count - 1 : 0;
      for (int unsigned k = 0; k <= da + db; k++) begin
        acc = '0;
        for (int unsigned i = 0; i <= da; i++) begin
          if (k >= i && k - i <= db) acc += first_store[i] * second_store[k - i];
        end
        t.coef = acc;
        t.power = k[POWER_W-1:0];
        t.final_term = (k == da + db);
        t.overflow = overflow_seen;
        pending_terms.push_back(t);
      end
      runs++;
      if (overflow_seen) overflow_runs++;
      clear_stores();
    endfunction

    function void compare_field(string name, logic [COEF_W-1:0] exp_v,
                                logic [COEF_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: mismatch on %s: expected %h actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_term(logic signed [COEF_W-1:0] coef, logic [POWER_W-1:0] power,
                             logic final_term, logic overflow);
      product_term_t t;
      if (pending_terms.size() == 0) begin
        $display("%0t: unexpected product term: expected none actual coef %h power %0d",
                 $time, coef, power);
        errors++;
        return;
      end
      t = pending_terms.pop_front();
      compare_field("product_coefficient", t.coef, coef);
      compare_field("power", COEF_W'(t.power), COEF_W'(power));
      compare_field("final_term", COEF_W'(t.final_term), COEF_W'(final_term));
      compare_field("overflow", COEF_W'(t.overflow), COEF_W'(overflow));
      terms_checked++;
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_operation = OP_LOAD_FIRST;
  logic signed [COEF_W-1:0] in_coefficient = '0;
  logic                     in_last = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [COEF_W-1:0] out_product_coefficient;
  logic [POWER_W-1:0]       out_power;
  logic                     out_final_term;
  logic                     out_overflow;

  poly_product_model model;
  int idle_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;

  integer_polynomial_multiply #(.MAX_DEGREE(MAX_DEGREE)) dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_operation            (in_operation),
    .in_coefficient          (in_coefficient),
    .in_last                 (in_last),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_product_coefficient (out_product_coefficient),
    .out_power               (out_power),
    .out_final_term          (out_final_term),
    .out_overflow            (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result sink: checks accepted terms and picks the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      model.check_term(out_product_coefficient, out_power, out_final_term, out_overflow);
    end
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return '0;
      4:       return $urandom_range(16) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Mostly short polynomials; now and then a long one or one that is one or two past full.
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(4, 1);
    if (r < 95) return $urandom_range(STORE_DEPTH, 5);
    return $urandom_range(STORE_DEPTH + 2, STORE_DEPTH + 1);
  endfunction

  task automatic send_request(input logic op, input logic [COEF_W-1:0] coef,
                              input logic lst);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_coefficient <= coef;
    in_last <= lst;
    do @(posedge clk); while (in_stall);
    model.note_request(op, coef, lst);
    requests_sent++;
  endtask

  task automatic send_poly(input logic op, input int len, input bit random_last);
    for (int i = 0; i < len; i++) begin
      send_request(op, pick_coef(), (i == len - 1) ? 1'b1 : (random_last && $urandom_range(1)));
    end
  endtask

  task automatic send_sequence();
    int kind;
    kind = $urandom_range(99);
    if (kind < 70) begin
      send_poly(OP_LOAD_FIRST, pick_length(), 1'b0);
      send_poly(OP_LOAD_SECOND, pick_length(), 1'b0);
    end else if (kind < 80) begin
      send_poly(OP_LOAD_SECOND, pick_length(), 1'b0);
    end else if (kind < 90) begin
      send_poly(OP_LOAD_FIRST, pick_length(), 1'b1);
      send_poly(OP_LOAD_SECOND, pick_length(), 1'b0);
    end else begin
      // Loose requests; a partial load may carry over into the next sequence.
      repeat ($urandom_range(4, 1)) begin
        send_request(logic'($urandom_range(1)), pick_coef(), logic'($urandom_range(1)));
      end
    end
  endtask

  task automatic run_directed();
    // Empty first polynomial against a single coefficient.
    send_request(OP_LOAD_SECOND, 32'sd7, 1'b1);
    // Extreme values; a last mark on the first polynomial does not close it.
    send_request(OP_LOAD_FIRST, 32'h8000_0000, 1'b0);
    send_request(OP_LOAD_FIRST, 32'h7fff_ffff, 1'b1);
    send_request(OP_LOAD_FIRST, 32'hffff_ffff, 1'b1);
    send_request(OP_LOAD_SECOND, 32'h8000_0000, 1'b0);
    send_request(OP_LOAD_SECOND, 32'h7fff_ffff, 1'b1);
    // Fill the second store, then drop the closing coefficient past full.
    for (int i = 0; i < STORE_DEPTH; i++) send_request(OP_LOAD_SECOND, pick_coef(), 1'b0);
    send_request(OP_LOAD_SECOND, pick_coef(), 1'b1);
  endtask

  initial begin
    int goal;
    model = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 81; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      if (phase == 0) run_directed();
      goal = requests_sent + RANDOM_ITEMS / PHASES;
      while (requests_sent < goal) send_sequence();
      in_valid <= 1'b0;
      do @(posedge clk); while (model.pending_terms.size() > 0);
    end
    repeat (40) @(posedge clk);
    $display("Sent %0d requests; checked %0d product terms over %0d runs.",
             requests_sent, model.terms_checked, model.runs);
    $display("Runs with dropped coefficients: %0d; mismatches: %0d.",
             model.overflow_runs, model.errors);
    if (model.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
